[rtl/core/assert_macros.svh]
// Assertion macros clocked on aclk and disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/taa_pkg.sv]
// Types and constants of the tile activity accumulator.
`default_nettype none

package taa_pkg;

    localparam int CFG_WIDTH = 11;
    localparam int POS_WIDTH = 10;
    localparam int DIV_STEPS = 10;

    localparam logic [3:0]  LEVEL_MAX = 4'd15;
    localparam logic [1:0]  HITS_MAX = 2'd2;
    localparam logic [10:0] SIZE_MAX = 11'd1024;

    localparam logic [7:0]  THRESHOLD_RESET = 8'd202;
    localparam logic [10:0] TILE_WIDTH_RESET = 11'd40;
    localparam logic [10:0] TILE_HEIGHT_RESET = 11'd60;
    localparam logic [10:0] IMAGE_WIDTH_RESET = 11'd320;
    localparam logic [10:0] IMAGE_HEIGHT_RESET = 11'd240;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        REG_THRESHOLD    = 3'd0,
        REG_TILE_WIDTH   = 3'd1,
        REG_TILE_HEIGHT  = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT = 3'd4
    } cfg_index_t;

    typedef enum logic [9:0] {
        ST_IDLE       = 10'b0000000001,
        ST_DIVX       = 10'b0000000010,
        ST_DIVY       = 10'b0000000100,
        ST_LOCATE     = 10'b0000001000,
        ST_BUMP       = 10'b0000010000,
        ST_ADVANCE    = 10'b0000100000,
        ST_WALK_READ  = 10'b0001000000,
        ST_WALK_EMIT  = 10'b0010000000,
        ST_WALK_OUT   = 10'b0100000000,
        ST_UNUSED     = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] pixel;
    } taa_in_t;

    typedef struct packed {
        logic [2:0] tile_column;
        logic [1:0] tile_row;
        logic [3:0] level;
        logic       last;
    } taa_out_t;

    typedef struct packed {
        logic [3:0] level;
        logic [1:0] hits;
    } tile_entry_t;

endpackage

`default_nettype wire

[rtl/core/tile_activity_accumulator_unit.sv]
// Tile activity accumulator: per-tile hit counting and end-of-frame level reports.
// Pixels arrive in raster order; each active one locates its tile through a
// shared restoring divider that produces one quotient bit per cycle, first column
// then row. An active pixel then reads its tile and, if inside the grid, bumps
// its hit count; every pixel then advances the position, and input is not taken
// again until the unit is back in idle. A clear stays in idle. The frame's last
// pixel then walks all COLUMNS*ROWS tiles through the tile memory (one read and
// one write port); each report is read, emitted and held until m_ready is high.
// Reports go column by column, rows inner, with last set on the final one. Reset
// and clear take effect at once through per-tile valid bits; no sweep follows reset.
`default_nettype none
`include "assert_macros.svh"

module tile_activity_accumulator_unit import taa_pkg::*; #(
    parameter int COLUMNS = 8,
    parameter int ROWS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  taa_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output taa_out_t             m_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data
);

    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AW = CW + RW;
    localparam int DEPTH = 1 << AW;

    state_t state_reg, state_next;

    logic [7:0]           threshold_reg;
    logic [CFG_WIDTH-1:0] tile_width_reg, tile_height_reg;
    logic [CFG_WIDTH-1:0] image_width_reg, image_height_reg;

    logic [POS_WIDTH-1:0] col_pos_reg, col_pos_next;
    logic [POS_WIDTH-1:0] row_pos_reg, row_pos_next;

    logic [CFG_WIDTH-1:0] div_rem_reg, div_rem_next;
    logic [POS_WIDTH-1:0] div_num_reg, div_num_next;
    logic [3:0]           div_cnt_reg, div_cnt_next;
    logic [POS_WIDTH-1:0] col_quot_reg, col_quot_next;
    logic [AW-1:0]        tile_addr_reg, tile_addr_next;

    logic [CW-1:0] walk_col_reg, walk_col_next;
    logic [RW-1:0] walk_row_reg, walk_row_next;

    logic [DEPTH-1:0] tile_valid_reg;
    tile_entry_t      tile_mem [DEPTH];
    tile_entry_t      mem_rdata_reg;
    logic             rd_valid_reg;
    logic [AW-1:0]    mem_raddr, mem_waddr;
    logic             mem_we;
    tile_entry_t      mem_wdata;
    logic             tile_clear;

    taa_out_t out_reg, out_next;
    logic     m_valid_reg, m_valid_next;

    logic [CFG_WIDTH-1:0] div_divisor;
    logic [CFG_WIDTH:0]   div_trial, div_diff;
    logic                 div_ge, div_last;
    logic [CFG_WIDTH-1:0] div_rem_step;
    logic [POS_WIDTH-1:0] div_num_step;

    logic [CFG_WIDTH-1:0] iw_clamped, ih_clamped;
    logic                 x_end, y_end, pixel_active, walk_last;
    tile_entry_t          rd_entry;
    logic [3:0]           level_new;
    logic [1:0]           hits_new;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= THRESHOLD_RESET;
            tile_width_reg   <= TILE_WIDTH_RESET;
            tile_height_reg  <= TILE_HEIGHT_RESET;
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD:    threshold_reg    <= cfg_data[7:0];
                REG_TILE_WIDTH:   tile_width_reg   <= cfg_data;
                REG_TILE_HEIGHT:  tile_height_reg  <= cfg_data;
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // shared restoring divider step
    assign div_divisor  = (state_reg == ST_DIVY) ? tile_height_reg : tile_width_reg;
    assign div_trial    = {div_rem_reg, div_num_reg[POS_WIDTH-1]};
    assign div_ge       = div_trial >= {1'b0, div_divisor};
    assign div_diff     = div_trial - {1'b0, div_divisor};
    assign div_rem_step = div_ge ? div_diff[CFG_WIDTH-1:0] : div_trial[CFG_WIDTH-1:0];
    assign div_num_step = {div_num_reg[POS_WIDTH-2:0], div_ge};
    assign div_last     = div_cnt_reg == 4'(DIV_STEPS - 1);

    assign iw_clamped = (image_width_reg == '0) ? 11'd1 :
                        (image_width_reg > SIZE_MAX) ? SIZE_MAX : image_width_reg;
    assign ih_clamped = (image_height_reg == '0) ? 11'd1 :
                        (image_height_reg > SIZE_MAX) ? SIZE_MAX : image_height_reg;
    assign x_end = (11'(col_pos_reg) + 11'd1) >= iw_clamped;
    assign y_end = (11'(row_pos_reg) + 11'd1) >= ih_clamped;

    assign pixel_active = (s_data.pixel > threshold_reg) && (tile_width_reg != '0)
                          && (tile_height_reg != '0);

    assign walk_last = (walk_col_reg == CW'(COLUMNS - 1)) && (walk_row_reg == RW'(ROWS - 1));

    assign rd_entry  = rd_valid_reg ? mem_rdata_reg : '0;
    assign hits_new  = (rd_entry.hits < HITS_MAX) ? rd_entry.hits + 2'd1 : rd_entry.hits;
    assign level_new = ((rd_entry.hits >= HITS_MAX) && (rd_entry.level < LEVEL_MAX)) ?
                       rd_entry.level + 4'd1 : rd_entry.level;

    assign mem_raddr = (state_reg == ST_LOCATE) ?
                       {col_quot_reg[CW-1:0], div_num_reg[RW-1:0]} :
                       {walk_col_reg, walk_row_reg};
    assign mem_waddr = (state_reg == ST_BUMP) ? tile_addr_reg : {walk_col_reg, walk_row_reg};

    always_comb begin
        state_next    = state_reg;
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        div_rem_next  = div_rem_reg;
        div_num_next  = div_num_reg;
        div_cnt_next  = div_cnt_reg;
        col_quot_next = col_quot_reg;
        tile_addr_next = tile_addr_reg;
        walk_col_next = walk_col_reg;
        walk_row_next = walk_row_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;
        mem_we        = 1'b0;
        mem_wdata     = '0;
        tile_clear    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.operation == OP_CLEAR) begin
                        col_pos_next = '0;
                        row_pos_next = '0;
                        tile_clear   = 1'b1;
                    end else if (pixel_active) begin
                        div_rem_next = '0;
                        div_num_next = col_pos_reg;
                        div_cnt_next = '0;
                        state_next   = ST_DIVX;
                    end else begin
                        state_next = ST_ADVANCE;
                    end
                end
            end
            ST_DIVX: begin
                div_rem_next = div_rem_step;
                div_num_next = div_num_step;
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_last) begin
                    col_quot_next = div_num_step;
                    div_rem_next  = '0;
                    div_num_next  = row_pos_reg;
                    div_cnt_next  = '0;
                    state_next    = ST_DIVY;
                end
            end
            ST_DIVY: begin
                div_rem_next = div_rem_step;
                div_num_next = div_num_step;
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_last) begin
                    state_next = ST_LOCATE;
                end
            end
            ST_LOCATE: begin
                if ((col_quot_reg < 10'(COLUMNS)) && (div_num_reg < 10'(ROWS))) begin
                    tile_addr_next = mem_raddr;
                    state_next     = ST_BUMP;
                end else begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_BUMP: begin
                mem_we          = 1'b1;
                mem_wdata.level = rd_entry.level;
                mem_wdata.hits  = hits_new;
                state_next      = ST_ADVANCE;
            end
            ST_ADVANCE: begin
                if (x_end && y_end) begin
                    walk_col_next = '0;
                    walk_row_next = '0;
                    state_next    = ST_WALK_READ;
                end else if (x_end) begin
                    col_pos_next = '0;
                    row_pos_next = row_pos_reg + 10'd1;
                    state_next   = ST_IDLE;
                end else begin
                    col_pos_next = col_pos_reg + 10'd1;
                    state_next   = ST_IDLE;
                end
            end
            ST_WALK_READ: begin
                state_next = ST_WALK_EMIT;
            end
            ST_WALK_EMIT: begin
                mem_we               = 1'b1;
                mem_wdata.level      = level_new;
                mem_wdata.hits       = '0;
                out_next.tile_column = 3'(walk_col_reg);
                out_next.tile_row    = 2'(walk_row_reg);
                out_next.level       = level_new;
                out_next.last        = walk_last;
                m_valid_next         = 1'b1;
                state_next           = ST_WALK_OUT;
            end
            ST_WALK_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (walk_last) begin
                        col_pos_next = '0;
                        row_pos_next = '0;
                        state_next   = ST_IDLE;
                    end else begin
                        if (walk_row_reg == RW'(ROWS - 1)) begin
                            walk_row_next = '0;
                            walk_col_next = walk_col_reg + CW'(1);
                        end else begin
                            walk_row_next = walk_row_reg + RW'(1);
                        end
                        state_next = ST_WALK_READ;
                    end
                end
            end
            default: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            col_pos_reg    <= '0;
            row_pos_reg    <= '0;
            m_valid_reg    <= 1'b0;
            tile_valid_reg <= '0;
        end else begin
            state_reg   <= state_next;
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            m_valid_reg <= m_valid_next;
            if (tile_clear) begin
                tile_valid_reg <= '0;
            end else if (mem_we) begin
                tile_valid_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        div_rem_reg   <= div_rem_next;
        div_num_reg   <= div_num_next;
        div_cnt_reg   <= div_cnt_next;
        col_quot_reg  <= col_quot_next;
        tile_addr_reg <= tile_addr_next;
        walk_col_reg  <= walk_col_next;
        walk_row_reg  <= walk_row_next;
        out_reg       <= out_next;
    end

    // tile memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tile_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= tile_mem[mem_raddr];
        rd_valid_reg  <= tile_valid_reg[mem_raddr];
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `ASSERT_IMPLIES(a_ready_without_report, s_ready, !m_valid, "input ready while report pending")
    `ASSERT_NEXT(a_clear_single_cycle, s_valid && s_ready && s_data.operation == OP_CLEAR, s_ready && !m_valid, "clear did not return to idle")
    `ASSERT_NEXT(a_last_report_ends_walk, m_valid && m_ready && m_data.last, s_ready && !m_valid, "walk did not end after last report")

endmodule

`default_nettype wire
